/* design/fixed_block_pool_allocator_assert.svh */
// ----------------------------------------------------------------------------
// fixed block pool allocator assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FBPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fbpa check failed");
// next-cycle implication
`define FBPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fbpa check failed");
`else
`define FBPA_ASSERT_IMP(lbl, ante, cons)
`define FBPA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* design/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int CNT_W    = 7;
    localparam int STRIDE_W = 18;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    // request opcodes
    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_EXHAUSTED,
        STAT_BAD_ADDR,
        STAT_DOUBLE_FREE
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_HDR,
        S_OFFSET,
        S_SCAN,
        S_DONE
    } fbpa_state_t;

    // operations of the shared adder
    typedef enum logic [1:0] {
        UOP_ADD,
        UOP_SUB,
        UOP_ALIGN
    } unit_op_t;

    // mark store update command
    typedef struct packed {
        logic set;
        logic clr;
    } mark_op_t;

endpackage

/* design/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// fixed-size block pool: allocate grants the lowest unused block, free maps a
// payload address back to its block and releases it
// ----------------------------------------------------------------------------
//  channel   ports                     moves
//  -------   -----------------------   ----------------------------------------
//  s_        s_valid / s_ready         request: opcode, free address
//  m_        m_valid / m_ready         result: block address, status, free count
//  cfg_      cfg_wr_en                 register write: index, data
//
//  after the accepting edge a request runs address prep (align, add header,
//  offset), scans one block per cycle through the shared adder up to the
//  effective block count, then updates the mark and the result in a last
//  step; a new request is taken only once the sequencer is back in idle.
//  s_ready is high only while idle; a finished result waits in the output
//  register, and the sequencer holds in its last step until it is free.
//  reset (aresetn low, synchronous) clears marks, config, state and m_valid.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int ALIGN_MASK   = 7,
    parameter int HEADER_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [ADDR_W-1:0]    s_free_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_block_address,
    output logic [1:0]           m_status,
    output logic [CNT_W-1:0]     m_free_blocks,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [STRIDE_W-1:0] SMASK = STRIDE_W'(ALIGN_MASK);

    logic [ADDR_W-1:0]   pool_base_reg;
    logic [SIZE_W-1:0]   payload_size_reg;
    logic [CNT_W-1:0]    block_count_reg;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [CNT_W-1:0]    eff_count;

    logic [ADDR_W-1:0] unit_a;
    logic [ADDR_W-1:0] unit_b;
    logic [ADDR_W-1:0] unit_sum;
    unit_op_t          unit_op;
    logic              mark_rd;
    logic [IDX_W-1:0]  mark_idx;
    mark_op_t          mark_op;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg    <= '0;
            payload_size_reg <= '0;
            block_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POOL_BASE:    pool_base_reg    <= cfg_wdata;
                CFG_PAYLOAD_SIZE: payload_size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_BLOCK_COUNT:  block_count_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // block stride: payload plus header, aligned up
    assign stride_next = (STRIDE_W'(payload_size_reg) + STRIDE_W'(HEADER_BYTES) + SMASK)
                         & ~SMASK;

    always_ff @(posedge aclk) begin
        stride_reg <= stride_next;
    end

    // block count limited to the pool size
    assign eff_count = ({1'b0, block_count_reg} > 8'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                 : block_count_reg;

    fbpa_addu #(
        .ALIGN_MASK(ALIGN_MASK)
    ) u_addu (
        .a  (unit_a),
        .b  (unit_b),
        .op (unit_op),
        .sum(unit_sum)
    );

    fbpa_marks #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .IDX_W     (IDX_W)
    ) u_marks (
        .aclk   (aclk),
        .aresetn(aresetn),
        .idx    (mark_idx),
        .op     (mark_op),
        .rd_mark(mark_rd)
    );

    fbpa_ctrl #(
        .IDX_W       (IDX_W),
        .ALIGN_MASK  (ALIGN_MASK),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_free_address (s_free_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_address(m_block_address),
        .m_status       (m_status),
        .m_free_blocks  (m_free_blocks),
        .pool_base      (pool_base_reg),
        .stride         (stride_reg),
        .eff_count      (eff_count),
        .unit_sum       (unit_sum),
        .unit_a         (unit_a),
        .unit_b         (unit_b),
        .unit_op        (unit_op),
        .mark_rd        (mark_rd),
        .mark_idx       (mark_idx),
        .mark_op        (mark_op)
    );

endmodule

/* design/fbpa_addu.sv */
// ----------------------------------------------------------------------------
// fbpa_addu
// shared 32-bit adder: add, subtract, or add then align down
// ----------------------------------------------------------------------------
module fbpa_addu
    import fbpa_pkg::*;
#(
    parameter int ALIGN_MASK = 7
) (
    input  logic [ADDR_W-1:0] a,
    input  logic [ADDR_W-1:0] b,
    input  unit_op_t          op,
    output logic [ADDR_W-1:0] sum
);

    localparam logic [ADDR_W-1:0] MASK = ADDR_W'(ALIGN_MASK);

    logic [ADDR_W-1:0] b_eff;
    logic [ADDR_W-1:0] raw;

    // subtract is add of the complement with a carry in
    always_comb begin
        b_eff = (op == UOP_SUB) ? ~b : b;
        raw   = a + b_eff + ADDR_W'(op == UOP_SUB);
        sum   = (op == UOP_ALIGN) ? (raw & ~MASK) : raw;
    end

endmodule

/* design/fbpa_marks.sv */
// ----------------------------------------------------------------------------
// fbpa_marks
// one used mark per block, cleared at reset, read and updated at one index
// ----------------------------------------------------------------------------
module fbpa_marks
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int IDX_W      = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] idx,
    input  mark_op_t         op,
    output logic             rd_mark
);

    `include "fixed_block_pool_allocator_assert.svh"

    logic [MAX_BLOCKS-1:0] marks_reg;

    // mark update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
        end else if (op.set) begin
            marks_reg[idx] <= 1'b1;
        end else if (op.clr) begin
            marks_reg[idx] <= 1'b0;
        end
    end

    // mark read at the scan or update index
    assign rd_mark = marks_reg[idx];

    `FBPA_ASSERT_IMP(a_set_clr_excl, op.set, !op.clr)
    `FBPA_ASSERT_IMP(a_set_only_clear, op.set, !rd_mark)
    `FBPA_ASSERT_IMP(a_clr_only_used, op.clr, rd_mark)

endmodule

/* design/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpa_ctrl
// request sequencer: address prep, block scan through the shared adder,
// mark update and result register
// ----------------------------------------------------------------------------
module fbpa_ctrl
    import fbpa_pkg::*;
#(
    parameter int IDX_W        = 6,
    parameter int ALIGN_MASK   = 7,
    parameter int HEADER_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [ADDR_W-1:0]   s_free_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_block_address,
    output logic [1:0]          m_status,
    output logic [CNT_W-1:0]    m_free_blocks,
    input  logic [ADDR_W-1:0]   pool_base,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [CNT_W-1:0]    eff_count,
    input  logic [ADDR_W-1:0]   unit_sum,
    output logic [ADDR_W-1:0]   unit_a,
    output logic [ADDR_W-1:0]   unit_b,
    output unit_op_t            unit_op,
    input  logic                mark_rd,
    output logic [IDX_W-1:0]    mark_idx,
    output mark_op_t            mark_op
);

    `include "fixed_block_pool_allocator_assert.svh"

    fbpa_state_t state_reg, state_next;

    logic              opcode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] base_reg;      // aligned base, then base plus header
    logic [ADDR_W-1:0] target_reg;    // payload offset of a free request
    logic [ADDR_W-1:0] acc_reg;       // offset of block i
    logic [CNT_W-1:0]  i_reg;
    logic              found_reg;
    logic [CNT_W-1:0]  found_idx_reg;
    logic              found_used_reg;
    logic [ADDR_W-1:0] grant_off_reg;
    logic [CNT_W-1:0]  clear_cnt_reg;

    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] block_address_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  free_blocks_reg;

    logic accept;
    logic scan_end;
    logic hit;
    logic done_fire;

    assign accept    = s_valid && s_ready;
    assign scan_end  = (i_reg == eff_count);
    assign done_fire = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign hit       = (opcode_reg == OPC_ALLOC) ? !mark_rd : (acc_reg == target_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_ALIGN;
            S_ALIGN:  state_next = S_HDR;
            S_HDR:    state_next = S_OFFSET;
            S_OFFSET: state_next = S_SCAN;
            S_SCAN:   if (scan_end) state_next = S_DONE;
            S_DONE:   if (done_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: s_ready, adder operands and mark command
    always_comb begin
        s_ready     = 1'b0;
        unit_a      = acc_reg;
        unit_b      = ADDR_W'(stride);
        unit_op     = UOP_ADD;
        mark_idx    = IDX_W'(found_idx_reg);
        mark_op.set = 1'b0;
        mark_op.clr = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_ALIGN: begin
                unit_a  = pool_base;
                unit_b  = ADDR_W'(ALIGN_MASK);
                unit_op = UOP_ALIGN;
            end
            S_HDR: begin
                unit_a = base_reg;
                unit_b = ADDR_W'(HEADER_BYTES);
            end
            S_OFFSET: begin
                unit_a  = addr_reg;
                unit_b  = base_reg;
                unit_op = UOP_SUB;
            end
            S_SCAN: begin
                mark_idx = IDX_W'(i_reg);
            end
            S_DONE: begin
                unit_a      = base_reg;
                unit_b      = grant_off_reg;
                mark_op.set = done_fire && found_reg && (opcode_reg == OPC_ALLOC);
                mark_op.clr = done_fire && found_reg && found_used_reg &&
                              (opcode_reg == OPC_FREE);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // state and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (done_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // request capture, address prep and block scan
    always_ff @(posedge aclk) begin
        if (accept) begin
            opcode_reg    <= s_opcode;
            addr_reg      <= s_free_address;
            acc_reg       <= '0;
            i_reg         <= '0;
            found_reg     <= 1'b0;
            clear_cnt_reg <= '0;
        end
        if (state_reg == S_ALIGN || state_reg == S_HDR) begin
            base_reg <= unit_sum;
        end
        if (state_reg == S_OFFSET) begin
            target_reg <= unit_sum;
        end
        if (state_reg == S_SCAN && !scan_end) begin
            acc_reg       <= unit_sum;
            i_reg         <= i_reg + CNT_W'(1);
            clear_cnt_reg <= clear_cnt_reg + CNT_W'(!mark_rd);
            if (hit && !found_reg) begin
                found_reg      <= 1'b1;
                found_idx_reg  <= i_reg;
                found_used_reg <= mark_rd;
                grant_off_reg  <= acc_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (done_fire) begin
            if (opcode_reg == OPC_ALLOC) begin
                if (found_reg) begin
                    block_address_reg <= unit_sum;
                    status_reg        <= STAT_OK;
                    free_blocks_reg   <= clear_cnt_reg - CNT_W'(1);
                end else begin
                    block_address_reg <= '0;
                    status_reg        <= STAT_EXHAUSTED;
                    free_blocks_reg   <= clear_cnt_reg;
                end
            end else begin
                block_address_reg <= '0;
                if (!found_reg) begin
                    status_reg      <= STAT_BAD_ADDR;
                    free_blocks_reg <= clear_cnt_reg;
                end else if (!found_used_reg) begin
                    status_reg      <= STAT_DOUBLE_FREE;
                    free_blocks_reg <= clear_cnt_reg;
                end else begin
                    status_reg      <= STAT_OK;
                    free_blocks_reg <= clear_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_block_address = block_address_reg;
    assign m_status        = status_reg;
    assign m_free_blocks   = free_blocks_reg;

    `FBPA_ASSERT_IMP(a_scan_bound, state_reg == S_SCAN, i_reg <= eff_count)
    `FBPA_ASSERT_IMP(a_cnt_bound, state_reg == S_SCAN, clear_cnt_reg <= i_reg)
    `FBPA_ASSERT_NXT(a_done_valid, done_fire, m_valid_reg && state_reg == S_IDLE)
    `FBPA_ASSERT_IMP(a_no_accept_busy, s_valid && s_ready, state_reg == S_IDLE)

endmodule
